>>> design/pbp_pkg.sv
// Perceptron branch predictor package: constants, operation codes, state
// encoding and the payload and control structs. No dependencies.
package pbp_pkg;

  localparam int unsigned HISTORY_LEN_DEF = 32;
  localparam int unsigned TABLE_ROWS_DEF  = 256;
  localparam int unsigned WEIGHT_BITS_DEF = 8;

  localparam int unsigned LANES    = 8;
  localparam int unsigned LANE_W   = $clog2(LANES);
  localparam int unsigned CONF_W   = 13;
  localparam logic [CONF_W-1:0] CONF_MAX = '1;
  localparam int unsigned THR_W    = 7;
  localparam logic [THR_W-1:0] THR_RESET = 7'd75;

  typedef enum logic [1:0] {
    OP_PREDICT  = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_ALLOCATE = 2'd2
  } pbp_op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DECIDE,
    S_WRITE,
    S_WDRAIN
  } pbp_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] pc;
    logic        taken;
  } pbp_req_t;

  typedef struct packed {
    logic              predict_taken;
    logic [CONF_W-1:0] confidence;
    logic              trained;
  } pbp_rsp_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_pass;
    logic clr_en;
    logic decide;
    logic hist_shift;
  } pbp_cmd_t;

  typedef struct packed {
    logic last_chunk;
    logic clr_last;
    logic modify;
  } pbp_sts_t;

endpackage

>>> design/pbp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pbp_datapath.sv
// Perceptron datapath: weight and bias memories, history, chunk accumulator,
// training logic and result register. Depends on pbp_pkg and pbp_ram.
module pbp_datapath
  import pbp_pkg::*;
#(
  parameter int unsigned HISTORY_LEN = HISTORY_LEN_DEF,
  parameter int unsigned TABLE_ROWS  = TABLE_ROWS_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbp_req_t         req_i,
  input  logic             cfg_valid_i,
  input  logic [THR_W-1:0] cfg_data_i,
  input  pbp_cmd_t         cmd_i,
  output pbp_sts_t         sts_o,
  output logic             valid_o,
  output pbp_rsp_t         rsp_o
);

  localparam int unsigned ROW_W   = $clog2(TABLE_ROWS);
  localparam int unsigned NCHUNK  = (HISTORY_LEN + LANES - 1) / LANES;
  localparam int unsigned CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned ADDR_W  = ROW_W + CHUNK_W;
  localparam int unsigned WDEPTH  = TABLE_ROWS << CHUNK_W;
  localparam int unsigned HW      = LANES << CHUNK_W;
  localparam int unsigned WORD_W  = LANES * WEIGHT_BITS;
  localparam int unsigned SUM_W   = WEIGHT_BITS + $clog2(HISTORY_LEN + 1) + 1;
  localparam int unsigned MAG_W   = (SUM_W > CONF_W + 1) ? SUM_W : CONF_W + 1;
  localparam int unsigned CMP_W   = ((WEIGHT_BITS > THR_W) ? WEIGHT_BITS : THR_W) + 1;
  localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NCHUNK - 1);

  function automatic logic [HW-1:0] mk_mask();
    logic [HW-1:0] m;
    for (int i = 0; i < HW; i++) begin
      m[i] = (i < HISTORY_LEN);
    end
    return m;
  endfunction

  localparam logic [HW-1:0] LANE_MASK = mk_mask();

  function automatic logic [WEIGHT_BITS-1:0] sat_step(input logic [WEIGHT_BITS-1:0] w,
                                                      input logic up);
    logic [WEIGHT_BITS:0]   r;
    logic [WEIGHT_BITS-1:0] res;
    r = {w[WEIGHT_BITS-1], w} + (up ? (WEIGHT_BITS+1)'(1) : {(WEIGHT_BITS+1){1'b1}});
    if (r[WEIGHT_BITS] == r[WEIGHT_BITS-1]) begin
      res = r[WEIGHT_BITS-1:0];
    end else if (!r[WEIGHT_BITS]) begin
      res = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    end else begin
      res = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    end
    return res;
  endfunction

  logic [1:0]             op_q;
  logic                   taken_q;
  logic [ROW_W-1:0]       row_q;
  logic [THR_W-1:0]       thr_q;
  logic [HISTORY_LEN-1:0] hist_q;
  logic [CHUNK_W-1:0]     chunk_q, chunk_d;
  logic [ADDR_W-1:0]      clr_q;
  logic                   rd_vld_q;
  logic                   wr_pass_q;
  logic [CHUNK_W-1:0]     rd_chunk_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [WEIGHT_BITS-1:0] bias_q;
  logic                   train_q;
  logic                   valid_q;
  pbp_rsp_t               rsp_q, rsp_d;

  logic [WORD_W-1:0]      w_rdata;
  logic [WEIGHT_BITS-1:0] b_rdata;
  logic [WORD_W-1:0]      new_word;
  logic [SUM_W-1:0]       lane_sum;
  logic [HW-1:0]          hist_ext;
  logic [LANES-1:0]       hist_sel;
  logic [LANES-1:0]       mask_sel;

  logic                   pred;
  logic [SUM_W-1:0]       abs_sum;
  logic [MAG_W-1:0]       mag;
  logic                   train_now;
  logic                   nudge_now;
  logic                   modify;
  logic [WEIGHT_BITS-1:0] bias_new;

  logic                   w_we;
  logic [ADDR_W-1:0]      w_waddr;
  logic [WORD_W-1:0]      w_wdata;
  logic                   b_we;
  logic [ROW_W-1:0]       b_waddr;
  logic [WEIGHT_BITS-1:0] b_wdata;

  assign hist_ext = HW'(hist_q);
  assign hist_sel = hist_ext[{rd_chunk_q, LANE_W'(0)} +: LANES];
  assign mask_sel = LANE_MASK[{rd_chunk_q, LANE_W'(0)} +: LANES];

  always_comb begin
    logic [WEIGHT_BITS-1:0] w;
    logic [SUM_W-1:0]       wext;
    logic signed [CMP_W-1:0] wc;
    logic signed [CMP_W-1:0] lim_p;
    logic signed [CMP_W-1:0] lim_n;
    lane_sum = '0;
    new_word = w_rdata;
    lim_p    = CMP_W'(thr_q);
    lim_n    = -lim_p;
    for (int l = 0; l < LANES; l++) begin
      w    = w_rdata[l*WEIGHT_BITS +: WEIGHT_BITS];
      wext = {{(SUM_W-WEIGHT_BITS){w[WEIGHT_BITS-1]}}, w};
      wc   = {{(CMP_W-WEIGHT_BITS){w[WEIGHT_BITS-1]}}, w};
      if (mask_sel[l]) begin
        lane_sum = lane_sum + (hist_sel[l] ? wext : -wext);
        if (train_q) begin
          new_word[l*WEIGHT_BITS +: WEIGHT_BITS] = sat_step(w, hist_sel[l] == taken_q);
        end else if (hist_sel[l]) begin
          if (wc < lim_p) begin
            new_word[l*WEIGHT_BITS +: WEIGHT_BITS] = sat_step(w, 1'b1);
          end
        end else begin
          if (wc > lim_n) begin
            new_word[l*WEIGHT_BITS +: WEIGHT_BITS] = sat_step(w, 1'b0);
          end
        end
      end
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (rd_vld_q && !wr_pass_q) begin
      if (rd_chunk_q == '0) begin
        sum_d = {{(SUM_W-WEIGHT_BITS){b_rdata[WEIGHT_BITS-1]}}, b_rdata} + lane_sum;
      end else begin
        sum_d = sum_q + lane_sum;
      end
    end
  end

  always_comb begin
    pred      = !sum_q[SUM_W-1];
    abs_sum   = pred ? sum_q : -sum_q;
    mag       = MAG_W'(abs_sum);
    train_now = (op_q == OP_UPDATE) &&
                ((pred != taken_q) || (mag <= MAG_W'(thr_q)));
    nudge_now = (op_q == OP_ALLOCATE);
    modify    = train_now || nudge_now;
    bias_new  = sat_step(bias_q, train_now ? taken_q : 1'b1);
    rsp_d.predict_taken = pred;
    rsp_d.confidence    = (mag > MAG_W'(CONF_MAX)) ? CONF_MAX : mag[CONF_W-1:0];
    rsp_d.trained       = train_now;
  end

  assign chunk_d = (chunk_q == LAST_CHUNK) ? '0 : chunk_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      hist_q    <= '0;
      chunk_q   <= '0;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      wr_pass_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.hist_shift && op_q == OP_UPDATE) begin
        hist_q <= HISTORY_LEN'({hist_q, taken_q});
      end
      if (cmd_i.load) begin
        chunk_q <= '0;
      end else if (cmd_i.rd_en) begin
        chunk_q <= chunk_d;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
      rd_vld_q  <= cmd_i.rd_en;
      wr_pass_q <= cmd_i.wr_pass;
      valid_q   <= cmd_i.decide;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_i.operation;
      taken_q <= req_i.taken;
      row_q   <= req_i.pc[ROW_W-1:0];
    end
    rd_chunk_q <= chunk_q;
    sum_q      <= sum_d;
    if (rd_vld_q && !wr_pass_q && rd_chunk_q == '0) begin
      bias_q <= b_rdata;
    end
    if (cmd_i.decide) begin
      train_q <= train_now;
      rsp_q   <= rsp_d;
    end
  end

  assign w_we    = cmd_i.clr_en || (rd_vld_q && wr_pass_q);
  assign w_waddr = cmd_i.clr_en ? clr_q : {row_q, rd_chunk_q};
  assign w_wdata = cmd_i.clr_en ? '0 : new_word;
  assign b_we    = cmd_i.clr_en || (cmd_i.decide && modify);
  assign b_waddr = cmd_i.clr_en ? clr_q[ROW_W-1:0] : row_q;
  assign b_wdata = cmd_i.clr_en ? '0 : bias_new;

  pbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i ({row_q, chunk_q}),
    .rdata_o (w_rdata)
  );

  pbp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (TABLE_ROWS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (row_q),
    .rdata_o (b_rdata)
  );

  assign sts_o.last_chunk = (chunk_q == LAST_CHUNK);
  assign sts_o.clr_last   = &clr_q;
  assign sts_o.modify     = modify;
  assign valid_o          = valid_q;
  assign rsp_o            = rsp_q;

endmodule

>>> design/pbp_ctrl.sv
// Perceptron predictor controller: clear pass, read pass, decision and
// write-back sequencing. Depends on pbp_pkg.
module pbp_ctrl
  import pbp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pbp_sts_t sts_i,
  output pbp_cmd_t cmd_o
);

  pbp_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:   if (start) state_d = S_READ;
      S_READ:   if (sts_i.last_chunk) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_DECIDE;
      S_DECIDE: state_d = sts_i.modify ? S_WRITE : S_IDLE;
      S_WRITE:  if (sts_i.last_chunk) state_d = S_WDRAIN;
      S_WDRAIN: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_en = 1'b1;
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_READ:  cmd_o.rd_en = 1'b1;
      S_DRAIN: ;
      S_DECIDE: begin
        cmd_o.decide     = 1'b1;
        cmd_o.hist_shift = !sts_i.modify;
      end
      S_WRITE: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.wr_pass = 1'b1;
      end
      S_WDRAIN: cmd_o.hist_shift = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == S_READ)
    else $error("accepted transaction did not start the read pass");

  a_decide_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> !cmd_o.decide)
    else $error("decision issued twice for one transaction");

  a_write_after_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE && $past(state_q) == S_DECIDE |-> $past(sts_i.modify))
    else $error("write-back without a training decision");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> busy && !cmd_o.load)
    else $error("transaction accepted during clear pass");

endmodule

>>> design/perceptron_branch_predictor.sv
// Perceptron branch predictor top level: joins controller and datapath.
// Depends on pbp_pkg, pbp_ctrl and pbp_datapath.
//
// Usage:
//   Request channel: drive req_i and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low.
//   Result channel: valid_o is high for exactly one cycle with rsp_o; the
//   receiver cannot stall it, so it must capture the result in that cycle.
//   Config channel: cfg_data_i is written into the training threshold when
//   cfg_valid_i and cfg_ready_o are both high; write it only while idle.
//   Sequence: a row is read eight weights per cycle, in NCHUNK =
//   ceil(HISTORY_LEN/8) chunks per pass of the weight memory read port.
//   After the read pass come the drain and decide states; valid_o is
//   registered from the decision. A transaction that leaves the row unchanged
//   then frees the block; one that trains or nudges adds a write-back pass.
//   Reset: busy stays high for a clear pass over TABLE_ROWS << CHUNK_W weight
//   addresses (1024 at default sizes) that zeros the weight and bias memories;
//   the history resets to not taken and the threshold to 75.
module perceptron_branch_predictor
  import pbp_pkg::*;
#(
  parameter int unsigned HISTORY_LEN = HISTORY_LEN_DEF,
  parameter int unsigned TABLE_ROWS  = TABLE_ROWS_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pbp_req_t         req_i,
  output logic             valid_o,
  output pbp_rsp_t         rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [THR_W-1:0] cfg_data_i
);

  pbp_cmd_t cmd;
  pbp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pbp_datapath #(
    .HISTORY_LEN (HISTORY_LEN),
    .TABLE_ROWS  (TABLE_ROWS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o)
  );

endmodule
